>>> hw/rtl/tdh_pkg.sv
// shared types and constants of the two-dimensional histogram
`timescale 1ns / 1ps
package tdh_pkg;
   localparam int SAMPLE_W   = 16;
   localparam int DIFF_W     = SAMPLE_W + 1;
   localparam int WIDTH_W    = 16;
   localparam int BINS_W     = 17;
   localparam int GRID_W     = 2 * BINS_W;
   localparam int SUM_W      = GRID_W + 1;
   localparam int MEM_DEPTH  = 4096;
   localparam int MEM_AW     = $clog2(MEM_DEPTH);
   localparam int ADDR_W     = 12;
   localparam int COUNT_W    = 32;
   localparam int SEEN_W     = 32;
   localparam int FRAC_W     = 17;
   localparam int FRAC_SHIFT = 16;
   localparam int QUO_W      = COUNT_W + FRAC_SHIFT;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [BINS_W-1:0]  BINS_MAX  = {BINS_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [SEEN_W-1:0]  SEEN_MAX  = {SEEN_W{1'b1}};
   localparam logic [FRAC_W-1:0]  FRAC_ONE  = FRAC_W'(1) << FRAC_SHIFT;

   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_GRID  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_X     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_Y     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_W_X   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_W_Y   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMALIZE = 3'd6;

   typedef struct packed {
      logic [1:0]          op;
      logic [SAMPLE_W-1:0] sample_x;
      logic [SAMPLE_W-1:0] sample_y;
      logic [ADDR_W-1:0]   bin_address;
   } req_type;

   typedef struct packed {
      logic               binned;
      logic [COUNT_W-1:0] bin_count;
      logic [FRAC_W-1:0]  bin_fraction;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] min_x;
      logic [SAMPLE_W-1:0] min_y;
      logic [SAMPLE_W-1:0] max_x;
      logic [SAMPLE_W-1:0] max_y;
      logic [WIDTH_W-1:0]  bin_width_x;
      logic [WIDTH_W-1:0]  bin_width_y;
   } cfg_type;

   // one classified request handed from front to back
   typedef struct packed {
      logic [1:0]        op;
      logic              hit;
      logic              rd_ok;
      logic [1:0]        status;
      logic [MEM_AW-1:0] addr;
   } cmd_type;
endpackage

>>> hw/rtl/tdh_front.sv
// front end: takes requests, bins samples, derives grid size, classifies reads
`timescale 1ns / 1ps
module tdh_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  tdh_pkg::req_type req,
   input  tdh_pkg::cfg_type cfg,
   output logic            active,
   output logic            push,
   output tdh_pkg::cmd_type cmd
);
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DIV    = 2'd1;
   localparam logic [1:0] S_SETTLE = 2'd2;
   localparam logic [1:0] S_PUSH   = 2'd3;
   localparam int CNT_W = $clog2(tdh_pkg::DIFF_W + 1);

   logic [1:0] state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0] op_ff, op_in;
   logic [tdh_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic okx_ff, okx_in, oky_ff, oky_in;
   logic [tdh_pkg::DIFF_W-1:0] dvx_ff, dvx_in, dvy_ff, dvy_in;
   logic [tdh_pkg::WIDTH_W-1:0] remx_ff, remx_in, remy_ff, remy_in;
   logic [tdh_pkg::BINS_W-1:0] bx_ff, bx_in, by_ff, by_in;
   logic [tdh_pkg::GRID_W-1:0] gp_ff, prod_ff, prod_in;

   logic [tdh_pkg::WIDTH_W-1:0] wx, wy;
   logic [tdh_pkg::DIFF_W-1:0] difx, dify;
   logic inx, iny;
   logic [tdh_pkg::WIDTH_W:0] tx, ty;
   logic gex, gey;
   logic [tdh_pkg::BINS_W:0] nbx, nby;
   logic [tdh_pkg::SUM_W-1:0] flat;
   logic [tdh_pkg::GRID_W-1:0] rd_wide;
   logic too_big;

   assign wx = (cfg.bin_width_x == '0) ? tdh_pkg::WIDTH_W'(1) : cfg.bin_width_x;
   assign wy = (cfg.bin_width_y == '0) ? tdh_pkg::WIDTH_W'(1) : cfg.bin_width_y;

   always_comb begin
      // clear measures the range itself, a sample its offset from the minimum
      if (req.op == tdh_pkg::OP_CLEAR) begin
         difx = {cfg.max_x[tdh_pkg::SAMPLE_W-1], cfg.max_x}
              - {cfg.min_x[tdh_pkg::SAMPLE_W-1], cfg.min_x};
         dify = {cfg.max_y[tdh_pkg::SAMPLE_W-1], cfg.max_y}
              - {cfg.min_y[tdh_pkg::SAMPLE_W-1], cfg.min_y};
         inx = $signed(cfg.max_x) >= $signed(cfg.min_x);
         iny = $signed(cfg.max_y) >= $signed(cfg.min_y);
      end else begin
         difx = {req.sample_x[tdh_pkg::SAMPLE_W-1], req.sample_x}
              - {cfg.min_x[tdh_pkg::SAMPLE_W-1], cfg.min_x};
         dify = {req.sample_y[tdh_pkg::SAMPLE_W-1], req.sample_y}
              - {cfg.min_y[tdh_pkg::SAMPLE_W-1], cfg.min_y};
         inx = ($signed(req.sample_x) >= $signed(cfg.min_x))
            && ($signed(req.sample_x) <= $signed(cfg.max_x));
         iny = ($signed(req.sample_y) >= $signed(cfg.min_y))
            && ($signed(req.sample_y) <= $signed(cfg.max_y));
      end
   end

   assign tx  = {remx_ff, dvx_ff[tdh_pkg::DIFF_W-1]};
   assign ty  = {remy_ff, dvy_ff[tdh_pkg::DIFF_W-1]};
   assign gex = tx >= {1'b0, wx};
   assign gey = ty >= {1'b0, wy};
   assign nbx = {1'b0, dvx_ff} + (tdh_pkg::BINS_W + 1)'(1);
   assign nby = {1'b0, dvy_ff} + (tdh_pkg::BINS_W + 1)'(1);
   assign flat = {1'b0, prod_ff} + tdh_pkg::SUM_W'(dvy_ff);
   assign rd_wide = tdh_pkg::GRID_W'(addr_ff);
   assign too_big = gp_ff > tdh_pkg::GRID_W'(tdh_pkg::MEM_DEPTH);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      addr_in  = addr_ff;
      okx_in   = okx_ff;
      oky_in   = oky_ff;
      dvx_in   = dvx_ff;
      dvy_in   = dvy_ff;
      remx_in  = remx_ff;
      remy_in  = remy_ff;
      bx_in    = bx_ff;
      by_in    = by_ff;
      prod_in  = prod_ff;
      push     = 1'b0;
      cmd      = '0;
      cmd.op   = op_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req.op;
               addr_in  = req.bin_address;
               okx_in   = inx;
               oky_in   = iny;
               dvx_in   = inx ? difx : '0;
               dvy_in   = iny ? dify : '0;
               remx_in  = '0;
               remy_in  = '0;
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            remx_in = gex ? tdh_pkg::WIDTH_W'(tx - {1'b0, wx}) : tx[tdh_pkg::WIDTH_W-1:0];
            remy_in = gey ? tdh_pkg::WIDTH_W'(ty - {1'b0, wy}) : ty[tdh_pkg::WIDTH_W-1:0];
            dvx_in  = {dvx_ff[tdh_pkg::DIFF_W-2:0], gex};
            dvy_in  = {dvy_ff[tdh_pkg::DIFF_W-2:0], gey};
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(tdh_pkg::DIFF_W - 1)) begin
               state_in = S_SETTLE;
            end
         end
         S_SETTLE: begin
            prod_in  = tdh_pkg::GRID_W'(dvx_ff * by_ff);
            state_in = S_PUSH;
            if (op_ff == tdh_pkg::OP_CLEAR) begin
               bx_in = !okx_ff ? '0
                     : (nbx > {1'b0, tdh_pkg::BINS_MAX}) ? tdh_pkg::BINS_MAX
                     : nbx[tdh_pkg::BINS_W-1:0];
               by_in = !oky_ff ? '0
                     : (nby > {1'b0, tdh_pkg::BINS_MAX}) ? tdh_pkg::BINS_MAX
                     : nby[tdh_pkg::BINS_W-1:0];
               // a clear stays in settle until the grid product catches up with the new bin counts
               cnt_in = cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(tdh_pkg::DIFF_W)) begin
                  state_in = S_SETTLE;
               end
            end
         end
         S_PUSH: begin
            push     = 1'b1;
            state_in = S_IDLE;
            unique case (op_ff)
               tdh_pkg::OP_SAMPLE: begin
                  cmd.hit = okx_ff && oky_ff && (dvx_ff < bx_ff) && (dvy_ff < by_ff)
                         && (flat < tdh_pkg::SUM_W'(tdh_pkg::MEM_DEPTH));
                  cmd.addr   = flat[tdh_pkg::MEM_AW-1:0];
                  cmd.status = too_big ? tdh_pkg::ST_GRID : tdh_pkg::ST_OK;
               end
               tdh_pkg::OP_READ: begin
                  cmd.rd_ok = (rd_wide < gp_ff)
                           && (rd_wide < tdh_pkg::GRID_W'(tdh_pkg::MEM_DEPTH));
                  cmd.addr   = rd_wide[tdh_pkg::MEM_AW-1:0];
                  cmd.status = too_big ? tdh_pkg::ST_GRID
                             : (rd_wide < gp_ff) ? tdh_pkg::ST_OK : tdh_pkg::ST_RANGE;
               end
               tdh_pkg::OP_CLEAR: begin
                  cmd.status = too_big ? tdh_pkg::ST_GRID : tdh_pkg::ST_OK;
               end
               default: begin
                  cmd.status = tdh_pkg::ST_OK;
               end
            endcase
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         bx_ff    <= '0;
         by_ff    <= '0;
         gp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         bx_ff    <= bx_in;
         by_ff    <= by_in;
         gp_ff    <= tdh_pkg::GRID_W'(bx_ff * by_ff);
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      op_ff   <= op_in;
      addr_ff <= addr_in;
      okx_ff  <= okx_in;
      oky_ff  <= oky_in;
      dvx_ff  <= dvx_in;
      dvy_ff  <= dvy_in;
      remx_ff <= remx_in;
      remy_ff <= remy_in;
      prod_ff <= prod_in;
   end

   assign active = state_ff != S_IDLE;
endmodule

>>> hw/rtl/tdh_queue.sv
// two-entry command queue between front and back
`timescale 1ns / 1ps
module tdh_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  tdh_pkg::cmd_type din,
   input  logic            pop,
   output tdh_pkg::cmd_type head,
   output logic            empty,
   output logic            full
);
   tdh_pkg::cmd_type slot_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] fill_ff, fill_in;

   assign head  = slot_ff[rd_ptr_ff];
   assign empty = fill_ff == 2'd0;
   assign full  = fill_ff == 2'd2;
   assign fill_in = fill_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end
endmodule

>>> hw/rtl/tdh_back.sv
// back end: bin memory update, clearing sweeps, fraction divider, result register
`timescale 1ns / 1ps
module tdh_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             normalize,
   input  logic             q_empty,
   input  tdh_pkg::cmd_type  q_head,
   output logic             pop,
   output logic             init_busy,
   output logic             rsp_strobe,
   output tdh_pkg::rsp_type  rsp
);
   localparam logic [2:0] B_INIT  = 3'd0;
   localparam logic [2:0] B_IDLE  = 3'd1;
   localparam logic [2:0] B_EXEC  = 3'd2;
   localparam logic [2:0] B_FRAC  = 3'd3;
   localparam logic [2:0] B_CLEAR = 3'd4;
   localparam int K_W = $clog2(tdh_pkg::QUO_W);

   logic [2:0] state_ff, state_in;
   tdh_pkg::cmd_type cmd_ff, cmd_in;
   logic [tdh_pkg::SEEN_W-1:0] seen_ff, seen_in;
   logic [tdh_pkg::MEM_AW-1:0] sweep_ff, sweep_in;
   logic [tdh_pkg::QUO_W-1:0] dv_ff, dv_in;
   logic [tdh_pkg::SEEN_W-1:0] rem_ff, rem_in;
   logic [K_W-1:0] k_ff, k_in;
   logic strobe_ff, strobe_in;
   tdh_pkg::rsp_type rsp_ff, rsp_in;

   logic [tdh_pkg::COUNT_W-1:0] mem [tdh_pkg::MEM_DEPTH];
   logic [tdh_pkg::COUNT_W-1:0] rdata_ff;
   logic mem_we;
   logic [tdh_pkg::MEM_AW-1:0] mem_wa;
   logic [tdh_pkg::COUNT_W-1:0] mem_wd;

   logic [tdh_pkg::SEEN_W:0] t;
   logic ge;
   logic [tdh_pkg::QUO_W-1:0] quo;
   logic [tdh_pkg::COUNT_W-1:0] rd_count;
   logic sweep_last;

   assign t  = {rem_ff, dv_ff[tdh_pkg::QUO_W-1]};
   assign ge = t >= {1'b0, seen_ff};
   assign quo = {dv_ff[tdh_pkg::QUO_W-2:0], ge};
   assign rd_count = cmd_ff.rd_ok ? rdata_ff : '0;
   assign sweep_last = sweep_ff == tdh_pkg::MEM_AW'(tdh_pkg::MEM_DEPTH - 1);
   assign pop = (state_ff == B_IDLE) && !q_empty;

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      seen_in   = seen_ff;
      sweep_in  = sweep_ff;
      dv_in     = dv_ff;
      rem_in    = rem_ff;
      k_in      = k_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      mem_we    = 1'b0;
      mem_wa    = sweep_ff;
      mem_wd    = '0;
      unique case (state_ff)
         B_INIT: begin
            mem_we   = 1'b1;
            sweep_in = sweep_ff + tdh_pkg::MEM_AW'(1);
            if (sweep_last) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (!q_empty) begin
               cmd_in   = q_head;
               state_in = B_EXEC;
            end
         end
         B_EXEC: begin
            state_in = B_IDLE;
            rsp_in   = '0;
            rsp_in.status = cmd_ff.status;
            unique case (cmd_ff.op)
               tdh_pkg::OP_SAMPLE: begin
                  if (seen_ff != tdh_pkg::SEEN_MAX) begin
                     seen_in = seen_ff + tdh_pkg::SEEN_W'(1);
                  end
                  if (cmd_ff.hit) begin
                     mem_we = 1'b1;
                     mem_wa = cmd_ff.addr;
                     mem_wd = (rdata_ff == tdh_pkg::COUNT_MAX) ? rdata_ff
                            : rdata_ff + tdh_pkg::COUNT_W'(1);
                  end
                  rsp_in.binned = cmd_ff.hit;
                  strobe_in     = 1'b1;
               end
               tdh_pkg::OP_READ: begin
                  rsp_in.bin_count = rd_count;
                  if (normalize && (seen_ff != '0)) begin
                     dv_in    = {rd_count, tdh_pkg::FRAC_SHIFT'(0)};
                     rem_in   = '0;
                     k_in     = '0;
                     state_in = B_FRAC;
                  end else begin
                     strobe_in = 1'b1;
                  end
               end
               tdh_pkg::OP_CLEAR: begin
                  seen_in  = '0;
                  sweep_in = '0;
                  state_in = B_CLEAR;
               end
               default: begin
                  rsp_in.status = tdh_pkg::ST_OK;
                  strobe_in     = 1'b1;
               end
            endcase
         end
         B_FRAC: begin
            // restoring divide, one quotient bit per cycle
            rem_in = ge ? tdh_pkg::SEEN_W'(t - {1'b0, seen_ff}) : t[tdh_pkg::SEEN_W-1:0];
            dv_in  = quo;
            k_in   = k_ff + K_W'(1);
            if (k_ff == K_W'(tdh_pkg::QUO_W - 1)) begin
               rsp_in.bin_fraction = (quo > tdh_pkg::QUO_W'(tdh_pkg::FRAC_ONE))
                                   ? tdh_pkg::FRAC_ONE : quo[tdh_pkg::FRAC_W-1:0];
               strobe_in = 1'b1;
               state_in  = B_IDLE;
            end
         end
         B_CLEAR: begin
            mem_we   = 1'b1;
            sweep_in = sweep_ff + tdh_pkg::MEM_AW'(1);
            if (sweep_last) begin
               strobe_in = 1'b1;
               state_in  = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_INIT;
         sweep_ff  <= '0;
         seen_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         sweep_ff  <= sweep_in;
         seen_ff   <= seen_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      dv_ff   <= dv_in;
      rem_ff  <= rem_in;
      k_ff    <= k_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rdata_ff <= mem[q_head.addr];
   end

   assign init_busy  = state_ff == B_INIT;
   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;
endmodule

>>> hw/rtl/two_d_histogram_fixed_range.sv
// top level of the two-dimensional histogram over a fixed range
//
//   port group   direction  handshake
//   req_*        in         start high while busy low takes the request
//   rsp_*        out        rsp_strobe marks a result for one cycle
//   csr_*        in         csr_we writes register csr_index
//
// every request passes the front end: the 17-step binning divider, then a settle step
// that a clear repeats so the grid product catches up, then a push into the queue;
// the back end then executes it: sample, read or op 3 finish there, a normalized
// read runs the 48-step fraction divider, a clear sweeps one memory row per cycle.
// after reset every row of the bin memory is swept with busy high.
// a two-entry queue lets the front take the next request while the back works.
`timescale 1ns / 1ps
module two_d_histogram_fixed_range (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  tdh_pkg::req_type                 req_data,
   output logic                            rsp_strobe,
   output tdh_pkg::rsp_type                 rsp_data,
   input  logic                            csr_we,
   input  logic [tdh_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tdh_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   tdh_pkg::cfg_type cfg_ff;
   logic normalize_ff;
   logic front_active, push, pop, q_empty, q_full, init_busy, accept;
   tdh_pkg::cmd_type cmd, q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_x       <= '0;
         cfg_ff.min_y       <= '0;
         cfg_ff.max_x       <= tdh_pkg::SAMPLE_W'(32767);
         cfg_ff.max_y       <= tdh_pkg::SAMPLE_W'(32767);
         cfg_ff.bin_width_x <= tdh_pkg::WIDTH_W'(1024);
         cfg_ff.bin_width_y <= tdh_pkg::WIDTH_W'(1024);
         normalize_ff       <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            tdh_pkg::CSR_MIN_X:     cfg_ff.min_x       <= csr_wdata;
            tdh_pkg::CSR_MIN_Y:     cfg_ff.min_y       <= csr_wdata;
            tdh_pkg::CSR_MAX_X:     cfg_ff.max_x       <= csr_wdata;
            tdh_pkg::CSR_MAX_Y:     cfg_ff.max_y       <= csr_wdata;
            tdh_pkg::CSR_BIN_W_X:   cfg_ff.bin_width_x <= csr_wdata;
            tdh_pkg::CSR_BIN_W_Y:   cfg_ff.bin_width_y <= csr_wdata;
            tdh_pkg::CSR_NORMALIZE: normalize_ff       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign busy   = front_active || q_full || init_busy;
   assign accept = start && !busy;

   tdh_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cfg    (cfg_ff),
      .active (front_active),
      .push   (push),
      .cmd    (cmd)
   );

   tdh_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   (cmd),
      .pop   (pop),
      .head  (q_head),
      .empty (q_empty),
      .full  (q_full)
   );

   tdh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .normalize  (normalize_ff),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .pop        (pop),
      .init_busy  (init_busy),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_data)
   );
endmodule
